>>> sv/huffman_tree_six_bit_unpacker_assert.svh
// Assertion macros shared by the unpacker modules.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef HUFFMAN_TREE_SIX_BIT_UNPACKER_ASSERT_SVH
`define HUFFMAN_TREE_SIX_BIT_UNPACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HTU_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("unpacker check failed");

// Next-cycle implication, disabled during reset
`define HTU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("unpacker check failed");

`endif

>>> sv/htu_pkg.sv
// Shared types and constants of the six-bit Huffman unpacker.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package htu_pkg;

	// Input transfer payload
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} item_t;

	// Output transfer payload
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} result_t;

	localparam logic [7:0] LEAF_FLAG = 8'h80;
	localparam logic [6:0] SYM_MASK  = 7'h7f;
	localparam logic [1:0] PAIR_MASK = 2'h3;

	// Controller to datapath commands
	typedef struct packed {
		logic take_hdr;
		logic take_tree;
		logic start_walk;
		logic step;
		logic clear;
		logic pop;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic in_hdr;
		logic in_tree;
		logic last_bit;
		logic eof_pend;
		logic groups_nz;
		logic emit_last;
	} sts_t;

endpackage

>>> sv/htu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module htu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/htu_ctrl.sv
// Controller state machine of the unpacker: sequences load, walk and emit.
// Depends on htu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "huffman_tree_six_bit_unpacker_assert.svh"

module htu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_eof,
	output logic          item_stall,
	output logic          result_valid,
	input  logic          result_stall,
	input  htu_pkg::sts_t sts,
	output htu_pkg::cmd_t cmd
);
	import htu_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (sts.in_hdr) begin
						cmd.take_hdr = 1'b1;
						cmd.clear    = item_eof;
					end else if (sts.in_tree) begin
						cmd.take_tree = 1'b1;
						cmd.clear     = item_eof;
					end else begin
						cmd.start_walk = 1'b1;
						state_d        = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (sts.last_bit) begin
					cmd.clear = sts.eof_pend;
					state_d   = sts.groups_nz ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				cmd.pop = !result_stall;
				if (!result_stall && sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_EMIT);

	`HTU_ASSERT_NEXT(a_walk_ends, state_q == ST_WALK && sts.last_bit, state_q != ST_WALK)
	`HTU_ASSERT(a_take_idle, cmd.take_hdr || cmd.take_tree || cmd.start_walk, !item_stall)

endmodule

>>> sv/htu_dp.sv
// Datapath of the unpacker: header and tree load, bit walk, group packing
// and output buffer. Depends on htu_pkg, htu_ram and the assertion header.
`timescale 1ns / 1ps
`include "huffman_tree_six_bit_unpacker_assert.svh"

module htu_dp #(
	parameter int TREE_BYTES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  htu_pkg::item_t   item,
	input  htu_pkg::cmd_t    cmd,
	output htu_pkg::sts_t    sts,
	output htu_pkg::result_t result
);
	import htu_pkg::*;

	localparam int AW = $clog2(TREE_BYTES);
	localparam logic [8:0] TABLE_END = 9'(TREE_BYTES);

	logic [8:0]    pos_q;
	logic [7:0]    tlen_q;
	logic [6:0]    node_q;
	logic [1:0]    gcnt_q;
	logic [7:0]    grp_q [3];
	logic [7:0]    data_q;
	logic [2:0]    bit_q;
	logic          eof_q;
	logic          rd_ok_q;
	logic [7:0]    buf_q [2][3];
	logic [1:0]    ngrp_q;
	logic          slot_q;
	logic [1:0]    k_q;

	logic [8:0]    load_end;
	logic [8:0]    widx;
	logic          wr_en;
	logic [7:0]    rdata;
	logic [7:0]    br;
	logic          is_leaf;
	logic [6:0]    sym;
	logic [6:0]    node_nx;
	logic          emit_grp;
	logic [2:0]    bit_nx;
	logic [7:0]    raddr_full;
	logic          rd_ok;
	logic [7:0]    g0;
	logic [7:0]    g1;
	logic [7:0]    g2;
	logic [1:0]    ngrp_nx;

	// Phase of the file and tree write address
	assign load_end = {1'b0, tlen_q} + 9'd2;
	assign widx     = pos_q - 9'd1;
	assign wr_en    = cmd.take_tree && (widx < TABLE_END);

	// Branch taken for the current bit; out-of-table reads give the root
	assign br       = rd_ok_q ? rdata : 8'h00;
	assign is_leaf  = (br & LEAF_FLAG) != 8'h00;
	assign sym      = br[6:0] & SYM_MASK;
	assign node_nx  = is_leaf ? 7'd0 : br[6:0];
	assign emit_grp = is_leaf && (gcnt_q == 2'd3);

	// Spread the fourth symbol's pairs into the held bytes
	assign g0 = grp_q[0] | {(sym[5:4] & PAIR_MASK), 6'b0};
	assign g1 = grp_q[1] | {(sym[3:2] & PAIR_MASK), 6'b0};
	assign g2 = grp_q[2] | {(sym[1:0] & PAIR_MASK), 6'b0};

	assign ngrp_nx = (cmd.step && emit_grp) ? ngrp_q + 2'd1 : ngrp_q;

	// Next read: first bit from the input byte, later bits from the latched byte at the branch just read
	assign bit_nx     = bit_q - 3'd1;
	assign raddr_full = cmd.start_walk ? {node_q, ~item.data_byte[7]}
	                                   : {node_nx, ~data_q[bit_nx]};
	assign rd_ok      = ({1'b0, raddr_full} < load_end) && ({1'b0, raddr_full} < TABLE_END);

	htu_ram #(
		.WIDTH(8),
		.DEPTH(TREE_BYTES)
	) u_tree (
		.clk   (clk),
		.we    (wr_en),
		.waddr (widx[AW-1:0]),
		.wdata (item.data_byte),
		.raddr (raddr_full[AW-1:0]),
		.rdata (rdata)
	);

	// File position, tree size and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tlen_q <= '0;
			node_q <= '0;
			gcnt_q <= '0;
		end else if (cmd.clear) begin
			pos_q  <= '0;
			tlen_q <= '0;
			node_q <= '0;
			gcnt_q <= '0;
		end else if (cmd.take_hdr) begin
			tlen_q <= item.data_byte;
			pos_q  <= 9'd1;
		end else if (cmd.take_tree) begin
			pos_q <= pos_q + 9'd1;
		end else if (cmd.step) begin
			node_q <= node_nx;
			if (is_leaf) begin
				gcnt_q <= emit_grp ? 2'd0 : gcnt_q + 2'd1;
			end
		end
	end

	// Hold the first three symbols of a group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '{default: 8'h00};
		end else if (cmd.clear) begin
			grp_q <= '{default: 8'h00};
		end else if (cmd.step && is_leaf && !emit_grp) begin
			grp_q[gcnt_q] <= {1'b0, sym};
		end
	end

	// Latch the coded byte and advance the bit pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q   <= '0;
			eof_q   <= 1'b0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= rd_ok;
			if (cmd.start_walk) begin
				bit_q <= 3'd7;
				eof_q <= item.end_of_file;
			end else if (cmd.step) begin
				bit_q <= bit_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_walk) begin
			data_q <= item.data_byte;
		end
	end

	// Collect finished groups and drain them one byte per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ngrp_q <= '0;
			slot_q <= 1'b0;
			k_q    <= '0;
		end else if (cmd.start_walk) begin
			ngrp_q <= '0;
			slot_q <= 1'b0;
			k_q    <= '0;
		end else begin
			ngrp_q <= ngrp_nx;
			if (cmd.pop) begin
				if (k_q == 2'd2) begin
					k_q    <= '0;
					slot_q <= slot_q + 1'b1;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && emit_grp) begin
			buf_q[ngrp_q[0]][0] <= g0;
			buf_q[ngrp_q[0]][1] <= g1;
			buf_q[ngrp_q[0]][2] <= g2;
		end
	end

	assign sts.in_hdr    = (pos_q == 9'd0);
	assign sts.in_tree   = (pos_q != 9'd0) && (pos_q <= load_end);
	assign sts.last_bit  = (bit_q == 3'd0);
	assign sts.eof_pend  = eof_q;
	assign sts.groups_nz = (ngrp_nx != 2'd0);
	assign sts.emit_last = (k_q == 2'd2) && (({1'b0, slot_q} + 2'd1) == ngrp_q);

	assign result.out_byte = buf_q[slot_q][k_q];
	assign result.run_last = sts.emit_last;

	`HTU_ASSERT(a_grp_bound, 1'b1, ngrp_q != 2'd3)
	`HTU_ASSERT_NEXT(a_walk_start, cmd.start_walk, bit_q == 3'd7 && ngrp_q == 2'd0)

endmodule

>>> sv/huffman_tree_six_bit_unpacker.sv
// Six-bit Huffman unpacker, top level.
// Input channel item_valid/item_stall/item carries one file byte per transfer
// with an end-of-file flag. Output channel result_valid/result_stall/result
// carries one unpacked byte per transfer; run_last marks the last byte for an
// input byte. Header and tree bytes are taken back to back. A coded byte is
// accepted and then walked bit by bit, each step set by the dependent read
// of the node-table RAM (registered read, one lookup per cycle). Its results
// (none, three or six bytes) follow one per cycle while result_stall is low;
// item_stall stays high until the last is transferred. A stalled result holds
// its byte and flag. The final byte of a file returns the walk to the start of
// a new file; a partial group is dropped, the node table keeps its contents.
// Reset clears all control state; the node table needs no clearing, as only
// entries loaded for the current file are read.
// Depends on htu_pkg, htu_ctrl and htu_dp.
`timescale 1ns / 1ps

module huffman_tree_six_bit_unpacker #(
	parameter int TREE_BYTES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  htu_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output htu_pkg::result_t result
);
	import htu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	htu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_eof     (item.end_of_file),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	htu_dp #(
		.TREE_BYTES(TREE_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule
